// ===== design/dmn_pkg.sv =====
// Shared constants, types and codes for the distributed mutex node.
// Used by every module of the design; depends on nothing.
package dmn_pkg;

  localparam int MAX_NODES = 16;
  localparam int SEQ_BITS = 16;

  localparam int ID_W = 5;
  localparam int SEQ_W = 16;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam int NODE_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (NODE_W > ID_W) ? NODE_W : ID_W;
  localparam int PEND_W = $clog2(MAX_NODES);
  localparam int FLAG_IDX_W = $clog2(MAX_NODES);
  localparam int KIN_W = (SEQ_BITS > SEQ_W) ? SEQ_BITS : SEQ_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] MY_NODE_ID_RESET = CFG_DATA_W'(1);
  localparam logic [CFG_DATA_W-1:0] NODE_COUNT_RESET = CFG_DATA_W'(4);

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_REPLY   = 2'd1,
    OP_ENTER   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_REPLY   = 2'd1,
    KIND_GRANT   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REQ_SWEEP,
    ST_REL_SWEEP
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [CMP_W-1:0]    from;
    logic [SEQ_BITS-1:0] seq;
  } cmd_t;

  typedef struct packed {
    logic [CMP_W-1:0] my_id;
    logic [CMP_W-1:0] count;
  } node_cfg_t;

endpackage

// ===== design/dmn_front.sv =====
// Input front end: accepts events, saturates sequence numbers and drops
// malformed events before they reach the command queue. Depends on dmn_pkg.
module dmn_front import dmn_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [ID_W-1:0]       from_node,
  input  logic [SEQ_W-1:0]      seq_number,
  input  node_cfg_t             cfg,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  push_cmd
);

  logic [KIN_W-1:0] kin;
  logic [CMP_W-1:0] from_ext;
  logic             sender_ok;
  logic             my_id_ok;
  logic             keep;

  assign kin = KIN_W'(seq_number);
  assign from_ext = CMP_W'(from_node);

  assign sender_ok = (from_ext != '0) && (from_ext <= cfg.count) && (from_ext != cfg.my_id);
  assign my_id_ok = (cfg.my_id != '0) && (cfg.my_id <= cfg.count);

  always_comb begin
    case (op_t'(opcode))
      OP_REQUEST: keep = sender_ok;
      OP_REPLY:   keep = sender_ok;
      OP_ENTER:   keep = my_id_ok;
      OP_RELEASE: keep = 1'b1;
      default:    keep = 1'b0;
    endcase
  end

  always_comb begin
    push_cmd.op = op_t'(opcode);
    push_cmd.from = from_ext;
    if (kin > KIN_W'(SEQ_MAX)) begin
      push_cmd.seq = SEQ_MAX;
    end else begin
      push_cmd.seq = SEQ_BITS'(kin);
    end
  end

  assign in_stall = q_full;
  assign push = in_valid && !q_full && keep;

endmodule

// ===== design/dmn_queue.sv =====
// Short command queue that decouples the front end from the sequencer.
// Depends on dmn_pkg.
module dmn_queue import dmn_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t               entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;

  assign full = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/dmn_back.sv =====
// Protocol sequencer: holds the mutual exclusion state, executes queued
// events and drives the registered result stage. Depends on dmn_pkg.
module dmn_back import dmn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  node_cfg_t          cfg,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  kind,
  output logic [ID_W-1:0]    dest_node,
  output logic [SEQ_W-1:0]   seq_out,
  output logic               last
);

  state_t               state;
  state_t               state_next;
  logic [CMP_W-1:0]     idx;
  logic [CMP_W-1:0]     idx_next;
  logic                 requesting;
  logic                 requesting_next;
  logic [SEQ_BITS-1:0]  own_seq;
  logic [SEQ_BITS-1:0]  own_seq_next;
  logic [SEQ_BITS-1:0]  highest_seq;
  logic [SEQ_BITS-1:0]  highest_seq_next;
  logic [PEND_W-1:0]    pending;
  logic [PEND_W-1:0]    pending_next;
  logic [MAX_NODES-1:0] flags;
  logic [MAX_NODES-1:0] flags_next;

  logic                 out_free;
  logic                 node_is_me;
  logic [FLAG_IDX_W-1:0] flag_idx;
  logic                 flag_hit;
  logic [MAX_NODES-1:0] my_mask;
  logic [MAX_NODES-1:0] cur_mask;
  logic                 rest;
  logic                 end_req;
  logic                 end_rel;
  logic                 req_move;
  logic                 rel_move;
  logic                 defer;
  logic [SEQ_BITS-1:0]  next_own;

  logic                 emit;
  kind_t                e_kind;
  logic [ID_W-1:0]      e_dest;
  logic [SEQ_W-1:0]     e_seq;
  logic                 e_last;

  assign out_free = !out_valid || !out_stall;
  assign node_is_me = (idx == cfg.my_id);
  assign flag_idx = FLAG_IDX_W'(idx - 1'b1);
  assign flag_hit = flags[flag_idx] && !node_is_me;
  assign cur_mask = MAX_NODES'(1) << flag_idx;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      my_mask[i] = (cfg.my_id == CMP_W'(i + 1));
    end
  end

  assign rest = |(flags & ~cur_mask & ~my_mask);
  assign end_req = (idx == cfg.count);
  assign end_rel = (idx == CMP_W'(MAX_NODES));
  assign req_move = node_is_me || out_free;
  assign rel_move = !flag_hit || out_free;
  assign pop = (state == ST_IDLE) && q_valid && out_free;
  assign defer = requesting &&
                 ((q_cmd.seq > own_seq) || ((q_cmd.seq == own_seq) && (q_cmd.from > cfg.my_id)));
  assign next_own = (highest_seq == SEQ_MAX) ? SEQ_MAX : highest_seq + 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop && (q_cmd.op == OP_ENTER) && !requesting && (cfg.count != CMP_W'(1))) begin
          state_next = ST_REQ_SWEEP;
        end else if (pop && (q_cmd.op == OP_RELEASE)) begin
          state_next = ST_REL_SWEEP;
        end
      end
      ST_REQ_SWEEP: begin
        if (req_move && end_req) begin
          state_next = ST_IDLE;
        end
      end
      ST_REL_SWEEP: begin
        if (rel_move && end_rel) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    e_kind = KIND_REPLY;
    e_dest = '0;
    e_seq = '0;
    e_last = 1'b1;
    idx_next = idx;
    requesting_next = requesting;
    own_seq_next = own_seq;
    highest_seq_next = highest_seq;
    pending_next = pending;
    flags_next = flags;
    case (state)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            OP_REQUEST: begin
              if (q_cmd.seq > highest_seq) begin
                highest_seq_next = q_cmd.seq;
              end
              if (defer) begin
                flags_next[FLAG_IDX_W'(q_cmd.from - 1'b1)] = 1'b1;
              end else begin
                emit = 1'b1;
                e_kind = KIND_REPLY;
                e_dest = ID_W'(q_cmd.from);
              end
            end
            OP_REPLY: begin
              if (requesting && (pending != '0)) begin
                pending_next = pending - 1'b1;
                if (pending == PEND_W'(1)) begin
                  emit = 1'b1;
                  e_kind = KIND_GRANT;
                end
              end
            end
            OP_ENTER: begin
              if (!requesting) begin
                own_seq_next = next_own;
                requesting_next = 1'b1;
                pending_next = PEND_W'(cfg.count - 1'b1);
                idx_next = CMP_W'(1);
                if (cfg.count == CMP_W'(1)) begin
                  emit = 1'b1;
                  e_kind = KIND_GRANT;
                end
              end
            end
            OP_RELEASE: begin
              requesting_next = 1'b0;
              pending_next = '0;
              idx_next = CMP_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_REQ_SWEEP: begin
        if (req_move) begin
          idx_next = CMP_W'(idx + 1'b1);
          if (!node_is_me) begin
            emit = 1'b1;
            e_kind = KIND_REQUEST;
            e_dest = ID_W'(idx);
            e_seq = SEQ_W'(own_seq);
            e_last = end_req ||
                     ((CMP_W'(idx + 1'b1) == cfg.count) && (cfg.count == cfg.my_id));
          end
        end
      end
      ST_REL_SWEEP: begin
        if (rel_move) begin
          idx_next = CMP_W'(idx + 1'b1);
          flags_next[flag_idx] = 1'b0;
          if (flag_hit) begin
            emit = 1'b1;
            e_kind = KIND_REPLY;
            e_dest = ID_W'(idx);
            e_last = !rest;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      requesting <= 1'b0;
      own_seq <= '0;
      highest_seq <= '0;
      pending <= '0;
      flags <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      requesting <= requesting_next;
      own_seq <= own_seq_next;
      highest_seq <= highest_seq_next;
      pending <= pending_next;
      flags <= flags_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind <= e_kind;
      dest_node <= e_dest;
      seq_out <= e_seq;
      last <= e_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !requesting |-> (pending == '0))
    else $error("Replies pending while no request is outstanding.");

  assert property (@(posedge clk) disable iff (rst)
                   requesting |-> (CMP_W'(pending) < cfg.count))
    else $error("Pending reply count exceeds the number of other nodes.");

  assert property (@(posedge clk) disable iff (rst) (state == ST_REQ_SWEEP) |-> requesting)
    else $error("Request sweep running without an outstanding request.");

  assert property (@(posedge clk) disable iff (rst) (state == ST_REL_SWEEP) |-> !requesting)
    else $error("Release sweep running while still requesting.");

  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |-> !emit)
    else $error("Result written over a stalled beat.");

endmodule

// ===== design/distributed_mutex_node.sv =====
// Top level of one Ricart-Agrawala mutual exclusion node: configuration
// registers, front end, command queue and sequencer.
// Depends on dmn_pkg, dmn_front, dmn_queue and dmn_back.
//
//   Channel  Handshake                Beat contents
//   -------  -----------------------  -----------------------------------
//   input    in_valid / in_stall      opcode, from_node, seq_number
//   output   out_valid / out_stall    kind, dest_node, seq_out, last
//   config   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// An incoming request or reply is handled from idle, as is a local enter
// with no other node. A local enter with other nodes then sweeps node ids 1
// to node_count, and a release sweeps every node id up to MAX_NODES, one step
// per node id; a step that sends a beat waits while the output is stalled.
// Dropped events never reach the queue and take no sequencer time.
// Synchronous reset clears the protocol state, deferred flags and queue and
// restores my_node_id 1 and node_count 4. A two-entry queue lets the input
// side keep accepting while the sequencer waits on a stalled output beat.
module distributed_mutex_node import dmn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [ID_W-1:0]       from_node,
  input  logic [SEQ_W-1:0]      seq_number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     kind,
  output logic [ID_W-1:0]       dest_node,
  output logic [SEQ_W-1:0]      seq_out,
  output logic                  last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0] my_node_id;
  logic [CFG_DATA_W-1:0] node_count;
  logic [CMP_W-1:0]      count_raw;
  node_cfg_t             cfg;
  logic                  q_full;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  pop;
  logic                  q_valid;
  cmd_t                  q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_node_id <= MY_NODE_ID_RESET;
      node_count <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MY_NODE_ID: my_node_id <= cfg_data;
        CFG_NODE_COUNT: node_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign count_raw = CMP_W'(node_count);

  always_comb begin
    cfg.my_id = CMP_W'(my_node_id);
    if (count_raw == '0) begin
      cfg.count = CMP_W'(1);
    end else if (count_raw > CMP_W'(MAX_NODES)) begin
      cfg.count = CMP_W'(MAX_NODES);
    end else begin
      cfg.count = count_raw;
    end
  end

  dmn_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .from_node  (from_node),
    .seq_number (seq_number),
    .cfg        (cfg),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  dmn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  dmn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .dest_node (dest_node),
    .seq_out   (seq_out),
    .last      (last)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for distributed_mutex_node: a queue-fed input driver,
// random output stalls and a clocked monitor that predicts every output beat.
// Depends on dmn_pkg and the distributed_mutex_node design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmn_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4 * MAX_NODES;
  localparam int RANDOM_ITEMS = 360;
  localparam int QUIET_TAIL = 70;
  localparam int PHASE_ITEMS = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  from;
    logic [SEQ_W-1:0] seq;
  } event_t;

  typedef struct packed {
    kind_t            kind;
    logic [ID_W-1:0]  dest;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } msg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode = '0;
  logic [ID_W-1:0]       from_node = '0;
  logic [SEQ_W-1:0]      seq_number = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KIND_W-1:0]     kind;
  logic [ID_W-1:0]       dest_node;
  logic [SEQ_W-1:0]      seq_out;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  distributed_mutex_node uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted node state and configuration.
  logic [ID_W-1:0]      my_id = MY_NODE_ID_RESET;
  logic [ID_W-1:0]      node_total = NODE_COUNT_RESET;
  logic                 bidding = 1'b0;
  logic [SEQ_W-1:0]     my_ticket = '0;
  logic [SEQ_W-1:0]     top_ticket = '0;
  int                   replies_owed = 0;
  logic [MAX_NODES-1:0] deferred = '0;

  msg_t   outgoing_q[$];
  event_t pending_q[$];
  event_t next_ev;
  msg_t   want;
  int     items_queued = 0;
  int     items_taken = 0;
  int     errors = 0;
  int     quiet = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     seq_guess = 0;
  bit     idle_on = 1'b1;

  function automatic void apply_event(event_t ev);
    msg_t batch[$];
    int   cnt;
    int   i;
    bit   ok;
    cnt = (node_total == 0) ? 1 : (node_total > MAX_NODES) ? MAX_NODES : int'(node_total);
    ok = ev.from >= 1 && ev.from <= cnt && ev.from != my_id;
    case (ev.op)
      OP_REQUEST: if (ok) begin
        if (ev.seq > top_ticket) top_ticket = ev.seq;
        if (bidding && (ev.seq > my_ticket || (ev.seq == my_ticket && ev.from > my_id)))
          deferred[ev.from - 1'b1] = 1'b1;
        else
          batch.push_back('{KIND_REPLY, ev.from, SEQ_W'(0), 1'b0});
      end
      OP_REPLY: if (ok && bidding && replies_owed != 0) begin
        replies_owed--;
        if (replies_owed == 0) batch.push_back('{KIND_GRANT, ID_W'(0), SEQ_W'(0), 1'b0});
      end
      OP_ENTER: if (!bidding && my_id >= 1 && my_id <= cnt) begin
        my_ticket = (top_ticket != SEQ_MAX) ? top_ticket + 1'b1 : SEQ_MAX;
        bidding = 1'b1;
        replies_owed = 0;
        for (i = 1; i <= cnt; i++) begin
          if (i != my_id) begin
            batch.push_back('{KIND_REQUEST, ID_W'(i), my_ticket, 1'b0});
            replies_owed++;
          end
        end
        if (replies_owed == 0) batch.push_back('{KIND_GRANT, ID_W'(0), SEQ_W'(0), 1'b0});
      end
      OP_RELEASE: begin
        bidding = 1'b0;
        replies_owed = 0;
        for (i = 1; i <= MAX_NODES; i++) begin
          if (deferred[i-1] && i != my_id)
            batch.push_back('{KIND_REPLY, ID_W'(i), SEQ_W'(0), 1'b0});
        end
        deferred = '0;
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[b]) outgoing_q.push_back(batch[b]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        next_ev = pending_q.pop_front();
        in_valid <= 1'b1;
        opcode <= next_ev.op;
        from_node <= next_ev.from;
        seq_number <= next_ev.seq;
        if (idle_on && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MY_NODE_ID: my_id = cfg_data;
          CFG_NODE_COUNT: node_total = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        apply_event('{op_t'(opcode), from_node, seq_number});
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (outgoing_q.size() == 0) begin
          $error("unexpected beat: kind %0d dest_node %0d seq_out %0d last %0d",
                 kind, dest_node, seq_out, last);
          errors++;
        end else begin
          want = outgoing_q.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
          end
          if (dest_node !== want.dest) begin
            $error("dest_node: expected %0d, actual %0d", want.dest, dest_node);
            errors++;
          end
          if (seq_out !== want.seq) begin
            $error("seq_out: expected %0d, actual %0d", want.seq, seq_out);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send(op_t op, int from, int seq);
    pending_q.push_back('{op, ID_W'(from), SEQ_W'(seq)});
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (items_taken != items_queued || outgoing_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int near_seq();
    int s;
    s = seq_guess + int'($urandom_range(0, 4)) - 1;
    if (s < 0) s = 0;
    if (s > seq_guess) seq_guess = s;
    return s;
  endfunction

  function automatic int pick_peer(int id, int ec);
    int who;
    do who = $urandom_range(1, ec); while (who == id);
    return who;
  endfunction

  task automatic run_round(int id, int ec);
    int   peers[$];
    int   i;
    int   k;
    int   tmp;
    op_t  op;
    send(OP_ENTER, $urandom_range(0, 31), $urandom_range(0, 65535));
    for (i = 1; i <= ec; i++) if (i != id) peers.push_back(i);
    for (i = peers.size() - 1; i > 0; i--) begin
      k = $urandom_range(0, i);
      tmp = peers[i];
      peers[i] = peers[k];
      peers[k] = tmp;
    end
    for (i = 0; i < peers.size(); i++) begin
      if (ec > 1 && $urandom_range(0, 2) == 0) send(OP_REQUEST, pick_peer(id, ec), near_seq());
      if ($urandom_range(0, 9) == 0) begin
        op = op_t'($urandom_range(0, 3));
        send(op, $urandom_range(0, 31),
             (op == OP_REQUEST) ? near_seq() : int'($urandom_range(0, 65535)));
      end
      if ($urandom_range(0, 24) == 0) break;
      send(OP_REPLY, peers[i], $urandom_range(0, 65535));
    end
    if (ec > 1 && $urandom_range(0, 1) == 0) send(OP_REQUEST, pick_peer(id, ec), near_seq());
    if ($urandom_range(0, 5) == 0) send(OP_REPLY, $urandom_range(1, ec), 0);
    send(OP_RELEASE, $urandom_range(0, 31), $urandom_range(0, 65535));
  endtask

  initial begin : stimulus
    int id;
    int cnt;
    int ec;
    int base;
    int phase_end;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(OP_ENTER, 0, 0);
    send(OP_REPLY, 0, 0);
    send(OP_REPLY, 5, 0);
    send(OP_REPLY, 1, 0);
    send(OP_REQUEST, 3, 5);
    send(OP_REQUEST, 2, 1);
    send(OP_REQUEST, 4, 0);
    send(OP_REPLY, 2, 0);
    send(OP_REPLY, 3, 0);
    send(OP_REPLY, 4, 0);
    send(OP_REPLY, 2, 0);
    send(OP_ENTER, 0, 0);
    send(OP_RELEASE, 0, 0);
    send(OP_RELEASE, 0, 0);
    send(OP_REQUEST, 4, 2);
    send(OP_ENTER, 0, 0);
    send(OP_REPLY, 2, 0);
    send(OP_RELEASE, 0, 0);
    send(OP_REPLY, 3, 0);
    settle();
    write_reg(CFG_MY_NODE_ID, 3);
    send(OP_ENTER, 0, 0);
    send(OP_REQUEST, 2, 6);
    send(OP_REQUEST, 4, 6);
    send(OP_REQUEST, 1, 9);
    settle();
    // Node 4 holds a deferred flag and becomes this node's id before the release.
    write_reg(CFG_MY_NODE_ID, 4);
    send(OP_RELEASE, 0, 0);
    settle();
    write_reg(CFG_MY_NODE_ID, 1);
    write_reg(CFG_NODE_COUNT, 1);
    send(OP_ENTER, 0, 0);
    send(OP_RELEASE, 0, 0);
    settle();
    write_reg(CFG_MY_NODE_ID, 0);
    send(OP_ENTER, 0, 0);
    settle();
    write_reg(CFG_MY_NODE_ID, 2);
    write_reg(CFG_NODE_COUNT, 0);
    send(OP_ENTER, 0, 0);
    settle();
    write_reg(CFG_MY_NODE_ID, 1);
    send(OP_ENTER, 0, 0);
    send(OP_RELEASE, 0, 0);
    settle();
    write_reg(CFG_SPARE, 31);
    write_reg(CFG_MY_NODE_ID, 16);
    write_reg(CFG_NODE_COUNT, 31);
    send(OP_ENTER, 0, 0);
    send(OP_REQUEST, 17, 0);
    send(OP_REPLY, 15, 0);
    send(OP_RELEASE, 0, 0);
    settle();
    seq_guess = 9;

    base = items_queued;
    while (items_queued - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          cnt = 16;
          id = 16;
        end
        1: begin
          cnt = 2;
          id = $urandom_range(1, 2);
        end
        2: begin
          cnt = $urandom_range(0, 1) ? 31 : 0;
          id = $urandom_range(0, 1) ? 16 : 1;
        end
        3: begin
          cnt = $urandom_range(2, 16);
          id = $urandom_range(0, 1) ? 0 : $urandom_range(cnt + 1, 31);
        end
        default: begin
          cnt = $urandom_range(2, 16);
          id = $urandom_range(1, cnt);
        end
      endcase
      ec = (cnt == 0) ? 1 : (cnt > MAX_NODES) ? MAX_NODES : cnt;
      write_reg(CFG_MY_NODE_ID, id);
      write_reg(CFG_NODE_COUNT, cnt);
      if (items_queued - base > RANDOM_ITEMS - QUIET_TAIL) idle_on = 1'b0;
      phase_end = items_queued + PHASE_ITEMS;
      while (items_queued < phase_end) run_round(id, ec);
      settle();
    end

    // Sequence numbers at the maximum, with ties broken both ways by node id.
    idle_on = 1'b0;
    write_reg(CFG_MY_NODE_ID, 2);
    write_reg(CFG_NODE_COUNT, 3);
    send(OP_REQUEST, 1, 65535);
    send(OP_ENTER, 0, 0);
    send(OP_REQUEST, 3, 65535);
    send(OP_REQUEST, 1, 65535);
    send(OP_REPLY, 1, 0);
    send(OP_REPLY, 3, 0);
    send(OP_RELEASE, 0, 0);
    send(OP_ENTER, 0, 0);
    send(OP_RELEASE, 0, 0);
    settle();

    if (errors == 0 && outgoing_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dmn_pkg.sv
design/dmn_front.sv
design/dmn_queue.sv
design/dmn_back.sv
design/distributed_mutex_node.sv
tb/testbench.sv
